// ===== sv/shs_pkg.sv =====
// ---------------------------------------------------------------------------
// shs_pkg
// shared types, round constants and round functions for the sha-256 hasher
// ---------------------------------------------------------------------------
package shs_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_item_t;

  // head of the queue as seen by the engine
  typedef struct packed {
    logic      valid;
    msg_item_t item;
  } q_head_t;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_START_POS = 6'd56;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

// ===== sv/sha256_stream_hasher_top.sv =====
// flow: a full 64-byte block is loaded from the queue one byte at a time, run through the
//   compression rounds of the single round unit and chained with one add; no bytes are popped meanwhile
// end of message: after the end marker is loaded, padding fills the rest of the block byte by
//   byte (and a second padded block where the length does not fit), one or two compressions
//   follow, then eight digest words go out, each held until dig_ready
// reset: synchronous, clears the queue, bit count and flow state, loads the initial hash
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top
// byte-stream sha-256: input queue in front, block and round engine behind it
// ---------------------------------------------------------------------------
module sha256_stream_hasher_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_ready,
  input  shs_pkg::msg_item_t msg,
  output logic               dig_valid,
  input  logic               dig_ready,
  output shs_pkg::dig_item_t dig
);
  import shs_pkg::*;

  q_head_t head;
  logic    pop;

  shs_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .head      (head),
    .pop       (pop)
  );

  shs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

endmodule

// ===== sv/shs_front.sv =====
// ---------------------------------------------------------------------------
// shs_front
// accepts message items, drops empty ones and queues the rest for the engine
// ---------------------------------------------------------------------------
module shs_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_ready,
  input  shs_pkg::msg_item_t msg,
  output shs_pkg::q_head_t   head,
  input  logic               pop
);
  import shs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  msg_item_t       entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            do_pop;

  // an item with neither a byte nor an end marker changes nothing
  assign msg_ready = (count != FULL_CNT);
  assign push      = msg_valid && msg_ready && (msg.byte_present || msg.end_of_message);
  assign do_pop    = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= msg;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("engine popped an empty queue");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == FULL_CNT) && !do_pop |=> count == FULL_CNT)
    else $error("full queue changed without a pop");

endmodule

// ===== sv/shs_engine.sv =====
// ---------------------------------------------------------------------------
// shs_engine
// block assembly, padding, 64-round compression and digest output
// ---------------------------------------------------------------------------
module shs_engine (
  input  logic               clk,
  input  logic               rst,
  input  shs_pkg::q_head_t   head,
  output logic               pop,
  output logic               dig_valid,
  input  logic               dig_ready,
  output shs_pkg::dig_item_t dig
);
  import shs_pkg::*;

  typedef enum logic [2:0] {S_LOAD, S_PAD, S_ROUND, S_ADD, S_OUT} state_t;

  state_t        state;
  logic [511:0]  blk;          // word t of the schedule sits at the top
  logic [31:0]   wv [8];
  logic [31:0]   h [8];
  logic [5:0]    round;
  logic [5:0]    pos;
  logic [60:0]   byte_cnt;
  logic          pad_active;
  logic          mark_done;
  logic          len_mode;
  logic          last_blk;
  logic [2:0]    out_idx;

  logic [31:0]   w_cur;
  logic [31:0]   w_new;
  logic [31:0]   t1;
  logic [31:0]   t2;
  logic [63:0]   bit_len;
  logic [7:0]    len_byte;
  logic [7:0]    pad_byte;

  assign w_cur = blk[511:480];
  assign w_new = small_sig1(blk[63:32]) + blk[223:192] + small_sig0(blk[479:448]) + w_cur;
  assign t1    = wv[7] + big_sig1(wv[4]) + ch(wv[4], wv[5], wv[6]) + ROUND_K[round] + w_cur;
  assign t2    = big_sig0(wv[0]) + maj(wv[0], wv[1], wv[2]);

  assign bit_len  = {byte_cnt, 3'b000};
  assign len_byte = bit_len[{~pos[2:0], 3'b000} +: 8];

  always_comb begin
    priority if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (len_mode && pos >= LEN_START_POS) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign pop       = (state == S_LOAD) && head.valid;
  assign dig_valid = (state == S_OUT);
  assign dig.digest_word = h[out_idx];
  assign dig.word_index  = out_idx;
  assign dig.last_word   = (out_idx == LAST_WORD_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      round      <= '0;
      pos        <= '0;
      byte_cnt   <= '0;
      pad_active <= 1'b0;
      mark_done  <= 1'b0;
      len_mode   <= 1'b0;
      last_blk   <= 1'b0;
      out_idx    <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[i];
    end else begin
      unique case (state)
        S_LOAD: begin
          if (head.valid) begin
            if (head.item.byte_present) begin
              blk        <= {blk[503:0], head.item.message_byte};
              pos        <= pos + 1'b1;
              byte_cnt   <= byte_cnt + 1'b1;
              pad_active <= head.item.end_of_message;
              if (pos == LAST_BYTE_POS) begin
                for (int i = 0; i < 8; i++) wv[i] <= h[i];
                last_blk <= 1'b0;
                state    <= S_ROUND;
              end else if (head.item.end_of_message) begin
                state <= S_PAD;
              end
            end else begin
              // only end markers come through without a byte
              pad_active <= 1'b1;
              state      <= S_PAD;
            end
          end
        end
        S_PAD: begin
          blk <= {blk[503:0], pad_byte};
          pos <= pos + 1'b1;
          if (!mark_done) begin
            mark_done <= 1'b1;
            len_mode  <= (pos < LEN_START_POS);
          end
          if (pos == LAST_BYTE_POS) begin
            for (int i = 0; i < 8; i++) wv[i] <= h[i];
            last_blk <= mark_done && len_mode;
            state    <= S_ROUND;
          end
        end
        S_ROUND: begin
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          blk   <= {blk[479:0], w_new};
          round <= round + 1'b1;
          if (round == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + wv[i];
          priority if (last_blk) begin
            state <= S_OUT;
          end else if (pad_active) begin
            // a second padded block always carries the length
            if (mark_done) len_mode <= 1'b1;
            state <= S_PAD;
          end else begin
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          if (dig_ready) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == LAST_WORD_IDX) begin
              for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[i];
              byte_cnt   <= '0;
              pos        <= '0;
              pad_active <= 1'b0;
              mark_done  <= 1'b0;
              len_mode   <= 1'b0;
              last_blk   <= 1'b0;
              state      <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_ROUND |-> round == '0)
    else $error("round counter not at zero outside compression");
  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> pos == '0 && mark_done && len_mode)
    else $error("digest shown before padding finished");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && dig.last_word |=> byte_cnt == '0 && state == S_LOAD)
    else $error("length not cleared after digest");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |=> !pop || $past(round) == LAST_ROUND || state == S_LOAD)
    else $error("queue popped during compression");

endmodule
